/* sv/pts_pkg.sv */
// Shared types and constants for the polynomial term store evaluator.
// Holds the item structs, command and status codes, and the Horner phase codes.
// No dependencies.
package pts_pkg;

   localparam int MAX_DEGREE = 63;
   localparam int DEPTH      = MAX_DEGREE + 1;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXP_W      = 6;
   localparam int CMP_W      = (ADDR_W > EXP_W) ? ADDR_W : EXP_W;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_EVAL  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic [31:0] S32_MAX = {1'b0, {31{1'b1}}};
   localparam logic [31:0] S32_MIN = {1'b1, {31{1'b0}}};

   typedef struct packed {
      logic [1:0]         cmd;
      logic [EXP_W-1:0]   term_exponent;
      logic signed [31:0] term_coefficient;
      logic signed [15:0] point_x;
   } pts_req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         status;
   } pts_rsp_type;

   // one Horner step walks through these phases in order
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ABS,
      PH_MLO,
      PH_MHI,
      PH_RND,
      PH_ADD
   } pts_phase_type;

   typedef struct packed {
      logic          start;
      pts_phase_type phase;
   } pts_ctrl_type;

endpackage

/* sv/polynomial_term_store_evaluator.sv */
// Polynomial term store evaluator: coefficient store plus Horner sequencer.
// Request item carries cmd, term_exponent, term_coefficient and point_x;
// response item carries value and status, exactly one per request.
// Channels use valid/stall; an item moves when valid is high and stall low.
// Clear zeroes the whole store at once; add-term reads, adds with
// 32-bit saturation and writes back; evaluate runs Horner's rule over all
// MAX_DEGREE+1 entries with a shared 32x16 multiplier.
// Each Horner step runs five phases (abs, two multiplier passes, round,
// add) on one unit. One item is worked at a time; req_stall is high from
// accept until the result is moved into the response register.
// A response waiting under rsp_stall holds; the next request is still taken,
// and its result waits in the sequencer until the response register frees.
// Reset (synchronous) empties the store and drops any pending response.
// Depends on pts_pkg, pts_store and pts_horner.
module polynomial_term_store_evaluator import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pts_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pts_rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   pts_phase_type      phase_ff, phase_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic signed [31:0] coef_ff, coef_in;
   logic signed [63:0] res_value_ff, res_value_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               res_eval_ff, res_eval_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pts_rsp_type        rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [CMP_W-1:0]   expo_wide;
   logic               in_range;
   logic               clear;
   logic               wr_en;
   logic [31:0]        wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [31:0]        rd_data;
   logic [32:0]        add_sum;
   logic               add_sat;
   pts_ctrl_type       ctrl;
   logic signed [63:0] acc;
   logic               sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign expo_wide = CMP_W'(req_data.term_exponent);
   assign in_range  = (expo_wide <= CMP_W'(MAX_DEGREE));

   // add-term: 33-bit sum, clamped back to 32 bits
   assign add_sum = {rd_data[31], rd_data} + {coef_ff[31], coef_ff};
   assign add_sat = (add_sum[32] != add_sum[31]);
   assign wr_data = add_sat ? (add_sum[32] ? S32_MIN : S32_MAX) : add_sum[31:0];

   assign ctrl = '{start: accept && (req_data.cmd == CMD_EVAL),
                   phase: (state_ff == ST_EVAL) ? phase_ff : PH_IDLE};

   pts_store u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pts_horner u_horner (
      .clock   (clock),
      .ctrl    (ctrl),
      .point_x (req_data.point_x),
      .coef    (rd_data),
      .acc     (acc),
      .sat     (sat)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      coef_in       = coef_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      res_eval_in   = res_eval_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      clear         = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               coef_in       = req_data.term_coefficient;
               addr_in       = expo_wide[ADDR_W-1:0];
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               res_eval_in   = 1'b0;
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     clear    = 1'b1;
                     state_in = ST_DONE;
                  end
                  CMD_ADD: begin
                     if (in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = expo_wide[ADDR_W-1:0];
                        state_in = ST_ADD;
                     end else begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  CMD_EVAL: begin
                     cnt_in      = ADDR_W'(MAX_DEGREE);
                     phase_in    = PH_ABS;
                     res_eval_in = 1'b1;
                     state_in    = ST_EVAL;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            wr_en         = 1'b1;
            res_value_in  = {{32{wr_data[31]}}, wr_data};
            res_status_in = add_sat ? STATUS_SAT : STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_EVAL: begin
            unique case (phase_ff)
               PH_ABS: begin
                  // coefficient is fetched now, used in the add phase
                  rd_en    = 1'b1;
                  rd_addr  = cnt_ff;
                  phase_in = PH_MLO;
               end
               PH_MLO: phase_in = PH_MHI;
               PH_MHI: phase_in = PH_RND;
               PH_RND: phase_in = PH_ADD;
               PH_ADD: begin
                  if (cnt_ff == '0) begin
                     phase_in = PH_IDLE;
                     state_in = ST_DONE;
                  end else begin
                     cnt_in   = cnt_ff - 1'b1;
                     phase_in = PH_ABS;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (res_eval_ff) begin
                  rsp_data_in.value  = acc;
                  rsp_data_in.status = sat ? STATUS_SAT : STATUS_OK;
               end else begin
                  rsp_data_in.value  = res_value_ff;
                  rsp_data_in.status = res_status_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      addr_ff       <= addr_in;
      coef_ff       <= coef_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      res_eval_ff   <= res_eval_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/pts_store.sv */
// Dense coefficient store, one 32-bit entry per exponent, registered read.
// Per-entry valid bits make reset and clear take effect at once.
// Depends on pts_pkg.
module pts_store import pts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [31:0]        wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [31:0]      rd_mem_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_mem_ff <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // an entry never written since the last clear reads as zero
   assign rd_data = rd_vld_ff ? rd_mem_ff : 32'd0;

endmodule

/* sv/pts_horner.sv */
// Horner step datapath: one shared 32x16 multiplier, rounding and saturation.
// Each step takes five phases under control of the top-level sequencer.
// Depends on pts_pkg.
module pts_horner import pts_pkg::*; (
   input  logic               clock,
   input  pts_ctrl_type       ctrl,
   input  logic signed [15:0] point_x,
   input  logic signed [31:0] coef,
   output logic signed [63:0] acc,
   output logic               sat
);

   logic [15:0]        mx_ff;
   logic               negx_ff;
   logic signed [63:0] acc_ff;
   logic               nega_ff;
   logic [63:0]        ma_ff;
   logic [47:0]        plo_ff;
   logic [47:0]        phi_ff;
   logic [63:0]        mc_ff;
   logic               negm_ff;
   logic               sat_ff;

   logic [31:0] mul_a;
   logic [47:0] prod;
   logic [63:0] mag;
   logic        neg;
   logic        over;
   logic [65:0] term;
   logic [65:0] addend;
   logic [65:0] sum;

   // shared multiplier: low half of |acc| first, then the high half
   assign mul_a = (ctrl.phase == PH_MHI) ? ma_ff[63:32] : ma_ff[31:0];
   assign prod  = 48'(mul_a) * 48'(mx_ff);

   // |acc*x| rounded from Q.24 to Q.16, ties away from zero
   assign mag  = {1'b0, phi_ff[38:0], 24'd0} + 64'((plo_ff + 48'd128) >> 8);
   assign over = |phi_ff[47:39];
   assign neg  = nega_ff ^ negx_ff;

   // coefficient in Q.16 plus the signed scaled value, negation via carry-in
   assign term   = {{18{coef[31]}}, coef, 16'd0};
   assign addend = negm_ff ? ~{2'b00, mc_ff} : {2'b00, mc_ff};
   assign sum    = term + addend + 66'(negm_ff);

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mx_ff   <= point_x[15] ? 16'(-point_x) : point_x;
         negx_ff <= point_x[15];
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         unique case (ctrl.phase)
            PH_ABS: begin
               nega_ff <= acc_ff[63];
               ma_ff   <= acc_ff[63] ? 64'd0 - acc_ff : acc_ff;
            end
            PH_MLO: begin
               plo_ff <= prod;
            end
            PH_MHI: begin
               phi_ff <= prod;
            end
            PH_RND: begin
               negm_ff <= neg;
               if (over) begin
                  mc_ff  <= neg ? S64_MIN : S64_MAX;
                  sat_ff <= 1'b1;
               end else if (neg) begin
                  // magnitude 2^63 is exactly the most negative value
                  if (mag[63] && (|mag[62:0])) begin
                     mc_ff  <= S64_MIN;
                     sat_ff <= 1'b1;
                  end else begin
                     mc_ff <= mag;
                  end
               end else if (mag[63]) begin
                  mc_ff  <= S64_MAX;
                  sat_ff <= 1'b1;
               end else begin
                  mc_ff <= mag;
               end
            end
            PH_ADD: begin
               if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111) begin
                  acc_ff <= sum[63:0];
               end else begin
                  acc_ff <= sum[65] ? S64_MIN : S64_MAX;
                  sat_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign acc = acc_ff;
   assign sat = sat_ff;

endmodule
